// File: rtl/tcpu_pkg.sv
// Shared types, opcodes and decode helpers for the toy 16-bit CPU executor.
// No dependencies; tcpu_ctrl, tcpu_dp and the top level use it through tcpu_pkg:: names.
package tcpu_pkg;

  // Default main memory size in bytes (power of two, 256 to 65536)
  localparam int MEM_BYTES_DEF = 65536;

  // Register 15 serves as the stack pointer
  localparam logic [3:0] SP_IDX = 4'hf;
  // Stack step and program counter step, in bytes
  localparam logic [15:0] WORD_STEP = 16'd2;

  // Configuration register indexes
  localparam logic CFG_CPU_ID    = 1'b0;
  localparam logic CFG_CPU_COUNT = 1'b1;

  // Opcodes, numbered densely
  typedef enum logic [7:0] {
    OP_BAD    = 8'd0,  OP_PUSH  = 8'd1,  OP_POP   = 8'd2,  OP_MOV   = 8'd3,
    OP_LOAD   = 8'd4,  OP_STOR  = 8'd5,  OP_LOADB = 8'd6,  OP_STORB = 8'd7,
    OP_JMPR   = 8'd8,  OP_JMP   = 8'd9,  OP_CALLR = 8'd10, OP_CALL  = 8'd11,
    OP_RET    = 8'd12, OP_LOADI = 8'd13, OP_ADD   = 8'd14, OP_SUB   = 8'd15,
    OP_MUL    = 8'd16, OP_DIV   = 8'd17, OP_NEG   = 8'd18, OP_AND   = 8'd19,
    OP_OR     = 8'd20, OP_XOR   = 8'd21, OP_NOT   = 8'd22, OP_INC   = 8'd23,
    OP_DEC    = 8'd24, OP_SHL   = 8'd25, OP_SHR   = 8'd26, OP_TEST  = 8'd27,
    OP_CMP    = 8'd28, OP_EQU   = 8'd29, OP_BR    = 8'd30, OP_JR    = 8'd31,
    OP_CLD    = 8'd32, OP_STD   = 8'd33, OP_OUT   = 8'd34, OP_CPUID = 8'd35,
    OP_CPUNUM = 8'd36, OP_LOADA = 8'd37, OP_STORA = 8'd38, OP_SWAP  = 8'd39
  } opc_t;

  // Instruction classes that pick the micro-sequence
  typedef enum logic [2:0] {
    C_BAD, C_ALU, C_DIV, C_PUSH, C_READ, C_STORE
  } cls_t;

  // Controller states; the datapath action follows the state
  typedef enum logic [4:0] {
    S_IDLE, S_BWR, S_FOP, S_FARG, S_DEC, S_RX, S_RY, S_RS,
    S_I0, S_I1, S_I2, S_EXE, S_DIV, S_DWB,
    S_R0, S_R1, S_R2, S_WB, S_WB2, S_W0, S_W1, S_DONE
  } state_t;

  // Input word
  typedef struct packed {
    logic        action;
    logic [15:0] mem_address;
    logic [7:0]  mem_byte;
  } in_t;

  // Result word
  typedef struct packed {
    logic [15:0] next_pc;
    logic        char_valid;
    logic [7:0]  out_char;
    logic        bad_opcode;
    logic        cond_out;
    logic        debug_out;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    state_t act;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    cls_t cls;
    logic has_imm;
    logic div_last;
    logic is_pop;
    logic is_swap;
    logic is_byte_st;
  } sts_t;

  function automatic cls_t op_class(logic [7:0] op);
    cls_t c;
    c = C_ALU;
    unique case (op)
      OP_PUSH, OP_CALLR, OP_CALL:                     c = C_PUSH;
      OP_POP, OP_RET, OP_LOAD, OP_LOADA, OP_LOADB,
      OP_SWAP:                                        c = C_READ;
      OP_STOR, OP_STORA, OP_STORB:                    c = C_STORE;
      OP_DIV:                                         c = C_DIV;
      OP_MOV, OP_JMPR, OP_JMP, OP_LOADI, OP_ADD, OP_SUB, OP_MUL, OP_NEG,
      OP_AND, OP_OR, OP_XOR, OP_NOT, OP_INC, OP_DEC, OP_SHL, OP_SHR,
      OP_TEST, OP_CMP, OP_EQU, OP_BR, OP_JR, OP_CLD, OP_STD, OP_OUT,
      OP_CPUID, OP_CPUNUM:                            c = C_ALU;
      default:                                        c = C_BAD;
    endcase
    return c;
  endfunction

  function automatic logic op_has_imm(logic [7:0] op);
    return (op == OP_JMP) || (op == OP_CALL) || (op == OP_LOADI);
  endfunction

endpackage

// File: rtl/tcpu_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module tcpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // one port: a write also reads out the old data at that address
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

endmodule

// File: rtl/tcpu_ctrl.sv
// Sequencer for the toy CPU: memory byte writes, and fetch, operand read, execute micro-steps.
// Depends on tcpu_pkg.
module tcpu_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            action,
  input  tcpu_pkg::sts_t  sts,
  output logic            busy,
  output logic            out_valid,
  output tcpu_pkg::cmd_t  cmd
);

  tcpu_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcpu_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcpu_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = action ? tcpu_pkg::S_FOP : tcpu_pkg::S_BWR;
        end
      end
      tcpu_pkg::S_BWR:  state_nxt = tcpu_pkg::S_DONE;
      tcpu_pkg::S_FOP:  state_nxt = tcpu_pkg::S_FARG;
      tcpu_pkg::S_FARG: state_nxt = tcpu_pkg::S_DEC;
      tcpu_pkg::S_DEC:  state_nxt = tcpu_pkg::S_RX;
      tcpu_pkg::S_RX:   state_nxt = tcpu_pkg::S_RY;
      tcpu_pkg::S_RY:   state_nxt = tcpu_pkg::S_RS;
      tcpu_pkg::S_RS:   state_nxt = sts.has_imm ? tcpu_pkg::S_I0 : tcpu_pkg::S_EXE;
      tcpu_pkg::S_I0:   state_nxt = tcpu_pkg::S_I1;
      tcpu_pkg::S_I1:   state_nxt = tcpu_pkg::S_I2;
      tcpu_pkg::S_I2:   state_nxt = tcpu_pkg::S_EXE;
      tcpu_pkg::S_EXE: begin
        unique case (sts.cls)
          tcpu_pkg::C_DIV:   state_nxt = tcpu_pkg::S_DIV;
          tcpu_pkg::C_PUSH:  state_nxt = tcpu_pkg::S_W0;
          tcpu_pkg::C_READ:  state_nxt = tcpu_pkg::S_R0;
          tcpu_pkg::C_STORE: state_nxt = tcpu_pkg::S_W0;
          default:           state_nxt = tcpu_pkg::S_DONE;
        endcase
      end
      tcpu_pkg::S_DIV:  state_nxt = sts.div_last ? tcpu_pkg::S_DWB : tcpu_pkg::S_DIV;
      tcpu_pkg::S_DWB:  state_nxt = tcpu_pkg::S_DONE;
      tcpu_pkg::S_R0:   state_nxt = tcpu_pkg::S_R1;
      tcpu_pkg::S_R1:   state_nxt = tcpu_pkg::S_R2;
      tcpu_pkg::S_R2:   state_nxt = tcpu_pkg::S_WB;
      tcpu_pkg::S_WB: begin
        priority if (sts.is_pop) begin
          state_nxt = tcpu_pkg::S_WB2;
        end else if (sts.is_swap) begin
          state_nxt = tcpu_pkg::S_W0;
        end else begin
          state_nxt = tcpu_pkg::S_DONE;
        end
      end
      tcpu_pkg::S_WB2:  state_nxt = tcpu_pkg::S_DONE;
      tcpu_pkg::S_W0:   state_nxt = sts.is_byte_st ? tcpu_pkg::S_DONE : tcpu_pkg::S_W1;
      tcpu_pkg::S_W1:   state_nxt = tcpu_pkg::S_DONE;
      tcpu_pkg::S_DONE: state_nxt = tcpu_pkg::S_IDLE;
      default:          state_nxt = tcpu_pkg::S_IDLE;
    endcase
  end

  // outputs: the datapath action is the current state
  always_comb begin
    busy      = (state_r != tcpu_pkg::S_IDLE);
    out_valid = (state_r == tcpu_pkg::S_DONE);
    cmd.act   = state_r;
  end

endmodule

// File: rtl/tcpu_dp.sv
// Datapath of the toy CPU: register file, pc, flags, ALU, divider, memory port.
// Depends on tcpu_pkg and tcpu_ram.
module tcpu_dp #(
  parameter int MEM_BYTES = tcpu_pkg::MEM_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tcpu_pkg::in_t   in_word,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_wdata,
  input  tcpu_pkg::cmd_t  cmd,
  output tcpu_pkg::sts_t  sts,
  output tcpu_pkg::out_t  out_word
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [15:0] AddrMask = 16'(MEM_BYTES - 1);

  // architectural state
  logic [15:0] rf_r [16];
  logic [15:0] pc_r, pc_nxt;
  logic        cond_r, cond_nxt;
  logic        dbg_r, dbg_nxt;
  logic [15:0] cpu_id_r, cpu_cnt_r;

  // per-item working registers
  logic [7:0]  op_r, arg_r;
  logic [15:0] x_r, y_r, s_r, m_r, addr_r, wd_r;
  logic [15:0] rem_r, quo_r;
  logic [3:0]  cnt_r;
  logic        chv_r, bad_r;
  logic [7:0]  chr_r;
  // byte write fields, held from the accepting edge
  logic [15:0] bw_addr_r;
  logic [7:0]  bw_byte_r;

  // memory port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wd, ram_rd;

  tcpu_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk     (clk),
    .we      (ram_we),
    .addr    (ram_addr),
    .wdata   (ram_wd),
    .rdata_r (ram_rd)
  );

  logic [3:0]  ra, rb;
  logic [15:0] pc_inc1, pc_adv, addr_inc1, offset, sp_dec, sp_inc, rf_rd;
  logic [31:0] prod;
  logic [16:0] div_sh;
  logic        div_ge;
  tcpu_pkg::cls_t cls;

  assign ra        = arg_r[7:4];
  assign rb        = arg_r[3:0];
  assign pc_inc1   = pc_r + 16'd1;
  assign pc_adv    = (pc_r + tcpu_pkg::WORD_STEP) & AddrMask;
  assign addr_inc1 = addr_r + 16'd1;
  assign offset    = {{8{arg_r[7]}}, arg_r};
  assign sp_dec    = s_r - tcpu_pkg::WORD_STEP;
  assign sp_inc    = s_r + tcpu_pkg::WORD_STEP;
  assign prod      = y_r * x_r;
  assign div_sh    = {rem_r, quo_r[15]};
  assign div_ge    = (div_sh >= {1'b0, x_r});
  assign cls       = tcpu_pkg::op_class(op_r);

  // status to the sequencer
  always_comb begin
    sts.cls        = cls;
    sts.has_imm    = tcpu_pkg::op_has_imm(op_r);
    sts.div_last   = (cnt_r == 4'hf);
    sts.is_pop     = (op_r == tcpu_pkg::OP_POP);
    sts.is_swap    = (op_r == tcpu_pkg::OP_SWAP);
    sts.is_byte_st = (op_r == tcpu_pkg::OP_STORB);
  end

  // single register file read port, address picked by the step
  always_comb begin
    unique case (cmd.act)
      tcpu_pkg::S_RX: rf_rd = rf_r[ra];
      tcpu_pkg::S_RY: rf_rd = rf_r[rb];
      default:        rf_rd = rf_r[tcpu_pkg::SP_IDX];
    endcase
  end

  // memory address and write data
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = pc_r[AW-1:0];
    ram_wd   = wd_r[7:0];
    unique case (cmd.act)
      tcpu_pkg::S_BWR: begin
        ram_we   = 1'b1;
        ram_addr = bw_addr_r[AW-1:0];
        ram_wd   = bw_byte_r;
      end
      tcpu_pkg::S_FARG, tcpu_pkg::S_I1: ram_addr = pc_inc1[AW-1:0];
      tcpu_pkg::S_R0:                   ram_addr = addr_r[AW-1:0];
      tcpu_pkg::S_R1:                   ram_addr = addr_inc1[AW-1:0];
      tcpu_pkg::S_W0: begin
        ram_we   = 1'b1;
        ram_addr = addr_r[AW-1:0];
        ram_wd   = (op_r == tcpu_pkg::OP_STORB) ? wd_r[7:0] : wd_r[15:8];
      end
      tcpu_pkg::S_W1: begin
        ram_we   = 1'b1;
        ram_addr = addr_inc1[AW-1:0];
        ram_wd   = wd_r[7:0];
      end
      default: ram_addr = pc_r[AW-1:0];
    endcase
  end

  // register file write, pc, flags
  logic        rf_we;
  logic [3:0]  rf_wa;
  logic [15:0] rf_wd;

  always_comb begin
    rf_we    = 1'b0;
    rf_wa    = rb;
    rf_wd    = m_r;
    pc_nxt   = pc_r;
    cond_nxt = cond_r;
    dbg_nxt  = dbg_r;
    unique case (cmd.act)
      tcpu_pkg::S_DEC, tcpu_pkg::S_I2: pc_nxt = pc_adv;
      tcpu_pkg::S_EXE: begin
        if (cls == tcpu_pkg::C_PUSH) begin
          rf_we = 1'b1;
          rf_wa = tcpu_pkg::SP_IDX;
          rf_wd = sp_dec;
        end
        unique case (op_r)
          tcpu_pkg::OP_MOV:    begin rf_we = 1'b1; rf_wd = x_r; end
          tcpu_pkg::OP_LOADI:  begin rf_we = 1'b1; rf_wa = ra; rf_wd = m_r; end
          tcpu_pkg::OP_ADD:    begin rf_we = 1'b1; rf_wd = y_r + x_r; end
          tcpu_pkg::OP_SUB:    begin rf_we = 1'b1; rf_wd = y_r - x_r; end
          tcpu_pkg::OP_MUL:    begin rf_we = 1'b1; rf_wd = prod[15:0]; end
          tcpu_pkg::OP_NEG:    begin rf_we = 1'b1; rf_wa = ra; rf_wd = 16'd0 - x_r; end
          tcpu_pkg::OP_AND:    begin rf_we = 1'b1; rf_wd = y_r & x_r; end
          tcpu_pkg::OP_OR:     begin rf_we = 1'b1; rf_wd = y_r | x_r; end
          tcpu_pkg::OP_XOR:    begin rf_we = 1'b1; rf_wd = y_r ^ x_r; end
          tcpu_pkg::OP_NOT: begin
            rf_we = 1'b1; rf_wa = ra; rf_wd = {15'd0, (x_r == 16'd0)};
          end
          tcpu_pkg::OP_INC:    begin rf_we = 1'b1; rf_wa = ra; rf_wd = x_r + 16'd1; end
          tcpu_pkg::OP_DEC:    begin rf_we = 1'b1; rf_wa = ra; rf_wd = x_r - 16'd1; end
          tcpu_pkg::OP_SHL: begin
            rf_we = 1'b1;
            rf_wd = (x_r[15:4] != 12'd0) ? 16'd0 : (y_r << x_r[3:0]);
          end
          tcpu_pkg::OP_SHR: begin
            rf_we = 1'b1;
            rf_wd = (x_r[15:4] != 12'd0) ? 16'd0 : (y_r >> x_r[3:0]);
          end
          tcpu_pkg::OP_TEST:   cond_nxt = ((x_r & y_r) != 16'd0);
          tcpu_pkg::OP_CMP:    cond_nxt = (x_r < y_r);
          tcpu_pkg::OP_EQU:    cond_nxt = (x_r == y_r);
          tcpu_pkg::OP_BR: begin
            if (cond_r) begin
              pc_nxt = pc_r + offset - tcpu_pkg::WORD_STEP;
            end
          end
          tcpu_pkg::OP_JR:     pc_nxt = pc_r + offset - tcpu_pkg::WORD_STEP;
          tcpu_pkg::OP_JMPR, tcpu_pkg::OP_CALLR: pc_nxt = x_r;
          tcpu_pkg::OP_JMP, tcpu_pkg::OP_CALL:   pc_nxt = m_r;
          tcpu_pkg::OP_CLD:    dbg_nxt = 1'b0;
          tcpu_pkg::OP_STD:    dbg_nxt = 1'b1;
          tcpu_pkg::OP_CPUID:  begin rf_we = 1'b1; rf_wa = ra; rf_wd = cpu_id_r; end
          tcpu_pkg::OP_CPUNUM: begin rf_we = 1'b1; rf_wa = ra; rf_wd = cpu_cnt_r; end
          default: ;
        endcase
      end
      tcpu_pkg::S_DWB: begin
        rf_we = 1'b1;
        rf_wd = quo_r;
      end
      tcpu_pkg::S_WB: begin
        unique case (op_r)
          tcpu_pkg::OP_POP: begin
            rf_we = 1'b1; rf_wa = tcpu_pkg::SP_IDX; rf_wd = sp_inc;
          end
          tcpu_pkg::OP_RET: begin
            rf_we = 1'b1; rf_wa = tcpu_pkg::SP_IDX; rf_wd = sp_inc;
            pc_nxt = m_r;
          end
          tcpu_pkg::OP_LOADB:  begin rf_we = 1'b1; rf_wd = {8'd0, m_r[15:8]}; end
          tcpu_pkg::OP_SWAP:   begin rf_we = 1'b1; rf_wa = ra; rf_wd = m_r; end
          default:             begin rf_we = 1'b1; rf_wd = m_r; end
        endcase
      end
      tcpu_pkg::S_WB2: begin
        rf_we = 1'b1;
        rf_wa = ra;
        rf_wd = m_r;
      end
      default: ;
    endcase
  end

  // architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        rf_r[i] <= 16'd0;
      end
      pc_r      <= 16'd0;
      cond_r    <= 1'b0;
      dbg_r     <= 1'b0;
      cpu_id_r  <= 16'd0;
      cpu_cnt_r <= 16'd1;
      chv_r     <= 1'b0;
      bad_r     <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_r[rf_wa] <= rf_wd;
      end
      pc_r   <= pc_nxt;
      cond_r <= cond_nxt;
      dbg_r  <= dbg_nxt;
      if (cfg_we) begin
        if (cfg_index == tcpu_pkg::CFG_CPU_ID) begin
          cpu_id_r <= cfg_wdata;
        end else begin
          cpu_cnt_r <= cfg_wdata;
        end
      end
      // per-item result flags
      if (cmd.act == tcpu_pkg::S_BWR || cmd.act == tcpu_pkg::S_FOP) begin
        chv_r <= 1'b0;
        bad_r <= 1'b0;
      end else if (cmd.act == tcpu_pkg::S_EXE) begin
        chv_r <= (op_r == tcpu_pkg::OP_OUT);
        bad_r <= (cls == tcpu_pkg::C_BAD);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.act)
      // track the input word while idle; the accepting edge leaves it held
      tcpu_pkg::S_IDLE: begin
        bw_addr_r <= in_word.mem_address;
        bw_byte_r <= in_word.mem_byte;
      end
      tcpu_pkg::S_BWR:  chr_r <= 8'd0;
      tcpu_pkg::S_FARG: op_r  <= ram_rd;
      tcpu_pkg::S_DEC:  arg_r <= ram_rd;
      tcpu_pkg::S_RX:   x_r   <= rf_rd;
      tcpu_pkg::S_RY:   y_r   <= rf_rd;
      tcpu_pkg::S_RS:   s_r   <= rf_rd;
      tcpu_pkg::S_I2, tcpu_pkg::S_R2: m_r[7:0] <= ram_rd;
      tcpu_pkg::S_I1, tcpu_pkg::S_R1: m_r[15:8] <= ram_rd;
      tcpu_pkg::S_EXE: begin
        chr_r <= (op_r == tcpu_pkg::OP_OUT) ? x_r[7:0] : 8'd0;
        rem_r <= 16'd0;
        quo_r <= y_r;
        cnt_r <= 4'd0;
        wd_r  <= (op_r == tcpu_pkg::OP_CALLR || op_r == tcpu_pkg::OP_CALL) ? pc_r : x_r;
        unique case (cls)
          tcpu_pkg::C_PUSH:  addr_r <= sp_dec;
          tcpu_pkg::C_STORE: addr_r <= y_r;
          tcpu_pkg::C_READ: begin
            if (op_r == tcpu_pkg::OP_POP || op_r == tcpu_pkg::OP_RET) begin
              addr_r <= s_r;
            end else if (op_r == tcpu_pkg::OP_SWAP) begin
              addr_r <= y_r;
            end else begin
              addr_r <= x_r;
            end
          end
          default: ;
        endcase
      end
      // one quotient bit per cycle, restoring; a zero divisor yields all ones
      tcpu_pkg::S_DIV: begin
        rem_r <= div_ge ? 16'(div_sh - {1'b0, x_r}) : div_sh[15:0];
        quo_r <= {quo_r[14:0], div_ge};
        cnt_r <= cnt_r + 4'd1;
      end
      default: ;
    endcase
  end

  // result word
  always_comb begin
    out_word.next_pc    = pc_r;
    out_word.char_valid = chv_r;
    out_word.out_char   = chr_r;
    out_word.bad_opcode = bad_r;
    out_word.cond_out   = cond_r;
    out_word.debug_out  = dbg_r;
  end

endmodule

// File: rtl/toy_16bit_cpu_executor.sv
// Top level of the toy 16-bit CPU executor: sequencer plus datapath.
// Depends on tcpu_pkg, tcpu_ctrl, tcpu_dp (which holds tcpu_ram).
//
//  channel  | ports                            | transfer
//  ---------+----------------------------------+-------------------------------
//  input    | start, busy, in_word             | start high while busy low
//  result   | out_valid, out_word              | one-cycle strobe, no back-off
//  config   | cfg_we, cfg_index, cfg_wdata     | write when cfg_we high
//
// A memory byte write steps through S_BWR and then S_DONE, which holds the
// strobe; an instruction steps through fetch, decode, operand reads and
// execute, with the strobe in S_DONE, its last state before S_IDLE, its length set
// by the single-port main memory (read byte by byte), one register file read
// port, and the bit-serial divider. busy stays high through the strobe cycle.
// Reset is synchronous: registers, pc and flags clear; memory is not cleared.
module toy_16bit_cpu_executor #(
  parameter int MEM_BYTES = tcpu_pkg::MEM_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  tcpu_pkg::in_t   in_word,
  output logic            out_valid,
  output tcpu_pkg::out_t  out_word,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_wdata
);

  tcpu_pkg::cmd_t cmd;
  tcpu_pkg::sts_t sts;

  tcpu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .action    (in_word.action),
    .sts       (sts),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  tcpu_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_word  (out_word)
  );

endmodule
